// ===== rtl/rkes_pkg.sv =====
`timescale 1ns / 1ps

package rkes_pkg;

    // Shared shift-add multiplier geometry
    localparam int MUL_A_BITS   = 64;
    localparam int MUL_B_BITS   = 32;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS = 6;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CELL_AREA = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_COUNT = 2'd1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_DATA_BITS-1:0] CELL_AREA_RESET = 32'h0100_0000;
    localparam logic [CFG_DATA_BITS-1:0] INV_COUNT_RESET = 32'hFFFF_FFFF;

    // Multiplier request: operand b is left-justified, count gives its bit length
    typedef struct packed {
        logic                    start;
        logic [MUL_A_BITS-1:0]   a;
        logic [MUL_B_BITS-1:0]   b;
        logic [MUL_CNT_BITS-1:0] count;
    } mul_req_t;

    // Multiplier response: done pulses for one cycle, product holds until next start
    typedef struct packed {
        logic                  done;
        logic [MUL_P_BITS-1:0] product;
    } mul_rsp_t;

endpackage

// ===== rtl/rkes_serial_mul.sv =====
`timescale 1ns / 1ps

module rkes_serial_mul
    import rkes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [MUL_CNT_BITS-1:0] cnt_reg;
    logic [MUL_A_BITS-1:0]   a_reg;
    logic [MUL_B_BITS-1:0]   b_reg;
    logic [MUL_P_BITS-1:0]   acc_reg;
    logic [MUL_P_BITS-1:0]   acc_next;

    // Shift the partial product up and add a for each multiplier bit, MSB first
    always_comb
    begin
        acc_next = {acc_reg[MUL_P_BITS-2:0], 1'b0}
                 + (b_reg[MUL_B_BITS-1] ? MUL_P_BITS'(a_reg) : '0);
    end

    // Load on start, then step one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[MUL_B_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/rkes_serial_sqrt.sv =====
`timescale 1ns / 1ps

module rkes_serial_sqrt #(
    parameter int VALUE_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*VALUE_BITS:0]     radicand,
    output logic                      done,
    output logic [VALUE_BITS:0]       root
);

    localparam int ROOT_BITS = VALUE_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [ROOT_BITS:0]   rem_reg;
    logic [ROOT_BITS-1:0] root_reg;

    logic [ROOT_BITS+2:0] rem_shift;
    logic [ROOT_BITS+3:0] trial;
    logic                 neg;

    // Bring down the next radicand bit pair and try the next root bit
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial     = {1'b0, rem_shift} - {2'b00, root_reg, 2'b01};
        neg       = trial[ROOT_BITS+3];
    end

    // One root bit per cycle, restoring recurrence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(ROOT_BITS);
                rad_reg  <= {1'b0, radicand};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
                rem_reg  <= neg ? rem_shift[ROOT_BITS:0] : trial[ROOT_BITS:0];
                root_reg <= {root_reg[ROOT_BITS-2:0], ~neg};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/relativistic_kinetic_energy_sum_unit.sv =====
`timescale 1ns / 1ps
// Per accepted word: four squares on one bit-serial multiplier, then the square root at one bit per
// cycle, then the energy product and two 32-bit scaling multiplies on the same multiplier, then the sum
// update; a word that closes a set then loads the result word once the result register is free.
// The input stalls until a word is fully processed, so a new word is taken only after the last one is done;
// the result word waits in its own register. Reset (async, active low): sum, flag cleared, config to defaults.
module relativistic_kinetic_energy_sum_unit
    import rkes_pkg::*;
#(
    parameter int VALUE_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [VALUE_BITS-1:0]     rest_mass,
    input  logic [VALUE_BITS-1:0]     density_weight,
    input  logic [VALUE_BITS-1:0]     momentum_x,
    input  logic [VALUE_BITS-1:0]     momentum_y,
    input  logic [VALUE_BITS-1:0]     momentum_z,
    input  logic                      last_particle,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [63:0]               energy_total,
    output logic                      saturated,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int RAD_BITS   = 2 * VALUE_BITS + 1;
    localparam int ROOT_BITS  = VALUE_BITS + 1;
    localparam int B_SHIFT    = MUL_B_BITS - VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_WAIT,
        S_SQRT_WAIT,
        S_MN_WAIT,
        S_MCA_WAIT,
        S_MIPC_WAIT,
        S_EMIT
    } state_t;

    state_t                   state_reg;
    logic [CFG_DATA_BITS-1:0] cell_area_reg;
    logic [CFG_DATA_BITS-1:0] inv_count_reg;
    logic [VALUE_BITS-1:0]    mass_reg;
    logic [VALUE_BITS-1:0]    weight_reg;
    logic [VALUE_BITS-1:0]    mag_x_reg;
    logic [VALUE_BITS-1:0]    mag_y_reg;
    logic [VALUE_BITS-1:0]    mag_z_reg;
    logic                     last_reg;
    logic [1:0]               sq_cnt_reg;
    logic [RAD_BITS-1:0]      rad_reg;
    logic [63:0]              energy_sum_reg;
    logic                     overflow_seen_reg;
    logic                     out_valid_reg;
    logic [63:0]              energy_total_reg;
    logic                     saturated_reg;
    mul_req_t                 mul_req_reg;
    logic                     sqrt_start_reg;
    logic [RAD_BITS-1:0]      sqrt_rad_reg;

    mul_rsp_t                 mul_rsp;
    logic                     sqrt_done;
    logic [ROOT_BITS-1:0]     sqrt_root;

    logic [VALUE_BITS-1:0]    sq_operand;
    logic [RAD_BITS-1:0]      rad_next;
    logic [ROOT_BITS-1:0]     energy_val;
    logic                     t1_sat;
    logic [63:0]              t1_val;
    logic                     t2_sat;
    logic [63:0]              t2_val;
    logic [64:0]              acc_sum;
    logic [63:0]              energy_sum_next;
    logic                     emit_go;
    logic                     mul_start_next;
    logic                     sqrt_start_next;
    logic                     out_valid_next;

    // Magnitude of a two's complement momentum component
    function automatic logic [VALUE_BITS-1:0] magnitude(input logic [VALUE_BITS-1:0] v);
        magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // Pick the next momentum magnitude to square
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_operand = mag_x_reg;
            2'd1:    sq_operand = mag_y_reg;
            default: sq_operand = mag_z_reg;
        endcase
    end

    // Datapath between multiplier passes
    always_comb
    begin
        rad_next   = rad_reg + RAD_BITS'(mul_rsp.product[2*VALUE_BITS-1:0]);
        energy_val = (sqrt_root >= {1'b0, mass_reg})
                   ? sqrt_root - {1'b0, mass_reg} : '0;
        t1_sat     = (mul_rsp.product[MUL_P_BITS-1:64] != '0);
        t1_val     = t1_sat ? '1 : mul_rsp.product[63:0];
        t2_sat     = (mul_rsp.product[MUL_P_BITS-1:88] != '0);
        t2_val     = t2_sat ? '1 : mul_rsp.product[87:24];
        acc_sum    = {1'b0, energy_sum_reg} + {1'b0, mul_rsp.product[MUL_P_BITS-1:32]};
        energy_sum_next = acc_sum[64] ? '1 : acc_sum[63:0];
    end

    // Start pulses and result word valid for the next cycle
    always_comb
    begin
        emit_go         = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
        sqrt_start_next = (state_reg == S_SQ_WAIT) && mul_rsp.done && (sq_cnt_reg == 2'd3);
        unique case (state_reg)
            S_IDLE:      mul_start_next = in_valid;
            S_SQ_WAIT:   mul_start_next = mul_rsp.done && (sq_cnt_reg != 2'd3);
            S_SQRT_WAIT: mul_start_next = sqrt_done;
            S_MN_WAIT:   mul_start_next = mul_rsp.done;
            S_MCA_WAIT:  mul_start_next = mul_rsp.done;
            default:     mul_start_next = 1'b0;
        endcase
        if (emit_go)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_area_reg <= CELL_AREA_RESET;
            inv_count_reg <= INV_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CELL_AREA: cell_area_reg <= cfg_data;
                CFG_INV_COUNT: inv_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer: squares, root, scaling products, accumulate, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mass_reg          <= '0;
            weight_reg        <= '0;
            mag_x_reg         <= '0;
            mag_y_reg         <= '0;
            mag_z_reg         <= '0;
            last_reg          <= 1'b0;
            sq_cnt_reg        <= '0;
            rad_reg           <= '0;
            energy_sum_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            energy_total_reg  <= '0;
            saturated_reg     <= 1'b0;
            mul_req_reg       <= '0;
            sqrt_start_reg    <= 1'b0;
            sqrt_rad_reg      <= '0;
        end
        else
        begin
            mul_req_reg.start <= mul_start_next;
            sqrt_start_reg    <= sqrt_start_next;

            // Drop the result word once taken, load a new one on emit
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mass_reg          <= rest_mass;
                        weight_reg        <= density_weight;
                        mag_x_reg         <= magnitude(momentum_x);
                        mag_y_reg         <= magnitude(momentum_y);
                        mag_z_reg         <= magnitude(momentum_z);
                        last_reg          <= last_particle;
                        sq_cnt_reg        <= '0;
                        rad_reg           <= '0;
                        mul_req_reg.a     <= MUL_A_BITS'(rest_mass);
                        mul_req_reg.b     <= MUL_B_BITS'(rest_mass) << B_SHIFT;
                        mul_req_reg.count <= MUL_CNT_BITS'(VALUE_BITS);
                        state_reg         <= S_SQ_WAIT;
                    end
                end

                S_SQ_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        rad_reg <= rad_next;
                        if (sq_cnt_reg == 2'd3)
                        begin
                            sqrt_rad_reg   <= rad_next;
                            state_reg      <= S_SQRT_WAIT;
                        end
                        else
                        begin
                            sq_cnt_reg        <= sq_cnt_reg + 1'b1;
                            mul_req_reg.a     <= MUL_A_BITS'(sq_operand);
                            mul_req_reg.b     <= MUL_B_BITS'(sq_operand) << B_SHIFT;
                            mul_req_reg.count <= MUL_CNT_BITS'(VALUE_BITS);
                        end
                    end
                end

                S_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        mul_req_reg.a     <= MUL_A_BITS'(energy_val);
                        mul_req_reg.b     <= MUL_B_BITS'(weight_reg) << B_SHIFT;
                        mul_req_reg.count <= MUL_CNT_BITS'(VALUE_BITS);
                        state_reg         <= S_MN_WAIT;
                    end
                end

                S_MN_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        overflow_seen_reg <= overflow_seen_reg | t1_sat;
                        mul_req_reg.a     <= t1_val;
                        mul_req_reg.b     <= cell_area_reg;
                        mul_req_reg.count <= MUL_CNT_BITS'(MUL_B_BITS);
                        state_reg         <= S_MCA_WAIT;
                    end
                end

                S_MCA_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        overflow_seen_reg <= overflow_seen_reg | t2_sat;
                        mul_req_reg.a     <= t2_val;
                        mul_req_reg.b     <= inv_count_reg;
                        mul_req_reg.count <= MUL_CNT_BITS'(MUL_B_BITS);
                        state_reg         <= S_MIPC_WAIT;
                    end
                end

                S_MIPC_WAIT:
                begin
                    // Saturating accumulate of the scaled energy
                    if (mul_rsp.done)
                    begin
                        energy_sum_reg    <= energy_sum_next;
                        overflow_seen_reg <= overflow_seen_reg | acc_sum[64];
                        state_reg         <= last_reg ? S_EMIT : S_IDLE;
                    end
                end

                S_EMIT:
                begin
                    // Hold until the result register is free, then clear the sum
                    if (emit_go)
                    begin
                        energy_total_reg  <= energy_sum_reg;
                        saturated_reg     <= overflow_seen_reg;
                        energy_sum_reg    <= '0;
                        overflow_seen_reg <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    rkes_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req_reg),
        .rsp   (mul_rsp)
    );

    rkes_serial_sqrt #(
        .VALUE_BITS (VALUE_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_rad_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign energy_total = energy_total_reg;
    assign saturated    = saturated_reg;

endmodule

// ===== tb/relativistic_kinetic_energy_sum_unit_tb.sv =====
`timescale 1ns / 1ps

module relativistic_kinetic_energy_sum_unit_tb;
    import rkes_pkg::*;

    localparam int VALUE_BITS = 24;
    localparam int unsigned RUN_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 320;
    localparam int SATURATION_SET = 300;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [VALUE_BITS-1:0] mass;
        logic [VALUE_BITS-1:0] weight;
        logic [VALUE_BITS-1:0] px;
        logic [VALUE_BITS-1:0] py;
        logic [VALUE_BITS-1:0] pz;
        logic                  last;
    } particle_t;

    typedef struct {
        logic [63:0] total;
        logic        clipped;
    } energy_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [VALUE_BITS-1:0]     rest_mass = '0;
    logic [VALUE_BITS-1:0]     density_weight = '0;
    logic [VALUE_BITS-1:0]     momentum_x = '0;
    logic [VALUE_BITS-1:0]     momentum_y = '0;
    logic [VALUE_BITS-1:0]     momentum_z = '0;
    logic                      last_particle = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [63:0]               energy_total;
    logic                      saturated;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Shadow of the block: registers, running sum and expected totals
    logic [CFG_DATA_BITS-1:0] area_reg = CELL_AREA_RESET;
    logic [CFG_DATA_BITS-1:0] inv_count_reg = INV_COUNT_RESET;
    logic [63:0]              predicted_sum = '0;
    logic                     predicted_clip = 1'b0;
    energy_result_t           expected_totals[$];
    energy_result_t           head;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          out_hold_left = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;

    relativistic_kinetic_energy_sum_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rest_mass     (rest_mass),
        .density_weight(density_weight),
        .momentum_x    (momentum_x),
        .momentum_y    (momentum_y),
        .momentum_z    (momentum_z),
        .last_particle (last_particle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .energy_total  (energy_total),
        .saturated     (saturated),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive the result stall: long hold-off first, random stall otherwise
    always @(negedge clk)
    begin
        if (out_hold_left > 0)
        begin
            out_stall <= 1'b1;
            out_hold_left--;
        end
        else
        begin
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expected total
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("unexpected result word: energy_total=%h saturated=%b",
                       energy_total, saturated);
                error_count++;
            end
            else
            begin
                head = expected_totals.pop_front();
                if (energy_total !== head.total)
                begin
                    $error("energy_total mismatch: expected %h, got %h",
                           head.total, energy_total);
                    error_count++;
                end
                if (saturated !== head.clipped)
                begin
                    $error("saturated mismatch: expected %b, got %b",
                           head.clipped, saturated);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [VALUE_BITS-1:0] magnitude(logic [VALUE_BITS-1:0] raw);
        return raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    endfunction

    function automatic logic [33:0] floor_sqrt(logic [65:0] radicand);
        logic [33:0] root;
        logic [33:0] trial;
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = root | (34'd1 << b);
            if ({34'd0, trial} * {34'd0, trial} <= {2'b00, radicand})
                root = trial;
        end
        return root;
    endfunction

    // Product shifted right, clipped to 64 bits; the top bit flags the clip
    function automatic logic [64:0] mul_shift_clip(logic [63:0] a, logic [63:0] b,
                                                   int unsigned drop_bits);
        logic [127:0] full;
        full = ({64'd0, a} * {64'd0, b}) >> drop_bits;
        if (full[127:64] != '0)
            return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        return {1'b0, full[63:0]};
    endfunction

    // Add one particle's scaled kinetic energy; queue the total on the last one
    function automatic void accumulate_particle(particle_t p);
        logic [65:0]    ax;
        logic [65:0]    ay;
        logic [65:0]    az;
        logic [65:0]    radicand;
        logic [33:0]    root;
        logic [63:0]    kinetic;
        logic [64:0]    term;
        logic [64:0]    total;
        logic           clip;
        energy_result_t res;
        ax = 66'(magnitude(p.px));
        ay = 66'(magnitude(p.py));
        az = 66'(magnitude(p.pz));
        radicand = 66'(p.mass) * 66'(p.mass) + ax * ax + ay * ay + az * az;
        root = floor_sqrt(radicand);
        kinetic = (root >= 34'(p.mass)) ? 64'(root) - 64'(p.mass) : 64'd0;
        term = mul_shift_clip(kinetic, 64'(p.weight), 0);
        clip = term[64];
        term = mul_shift_clip(term[63:0], 64'(area_reg), 24);
        clip |= term[64];
        term = mul_shift_clip(term[63:0], 64'(inv_count_reg), 32);
        clip |= term[64];
        total = {1'b0, predicted_sum} + {1'b0, term[63:0]};
        if (total[64])
        begin
            predicted_sum = '1;
            clip = 1'b1;
        end
        else
        begin
            predicted_sum = total[63:0];
        end
        if (clip)
            predicted_clip = 1'b1;
        if (p.last)
        begin
            res.total = predicted_sum;
            res.clipped = predicted_clip;
            expected_totals.push_back(res);
            predicted_sum = '0;
            predicted_clip = 1'b0;
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(VALUE_BITS-1){1'b0}}};
            3: return {1'b0, {(VALUE_BITS-1){1'b1}}};
            4, 5: return VALUE_BITS'($urandom_range(0, 1 << 18));
            default: return VALUE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_register();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_BITS'($urandom_range(0, 1 << 25));
            default: return CFG_DATA_BITS'($urandom());
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        p.mass = pick_value();
        p.weight = pick_value();
        p.px = pick_value();
        p.py = pick_value();
        p.pz = pick_value();
        p.last = ($urandom_range(0, 3) == 0);
        return p;
    endfunction

    function automatic particle_t make_particle(logic [VALUE_BITS-1:0] mass,
                                                logic [VALUE_BITS-1:0] weight,
                                                logic [VALUE_BITS-1:0] px,
                                                logic [VALUE_BITS-1:0] py,
                                                logic [VALUE_BITS-1:0] pz,
                                                logic last);
        particle_t p;
        p.mass = mass;
        p.weight = weight;
        p.px = px;
        p.py = py;
        p.pz = pz;
        p.last = last;
        return p;
    endfunction

    // Offer one word, with an optional idle gap first; leave valid high on return
    task automatic send_particle(particle_t p);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 260) : $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        rest_mass <= p.mass;
        density_weight <= p.weight;
        momentum_x <= p.px;
        momentum_y <= p.py;
        momentum_z <= p.pz;
        last_particle <= p.last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_particle(p);
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected total has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_totals.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then let any particle that closes no set finish
    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] reg_index,
                                  logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (reg_index)
            CFG_CELL_AREA: area_reg = data;
            CFG_INV_COUNT: inv_count_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] area, logic [CFG_DATA_BITS-1:0] inv);
        settle_block();
        write_register(CFG_CELL_AREA, area);
        write_register(CFG_INV_COUNT, inv);
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_SPARE_2, CFG_DATA_BITS'($urandom()));
        else
            write_register(CFG_SPARE_3, CFG_DATA_BITS'($urandom()));
    endtask

    // Change idle rates only while valid is low
    task automatic set_idling(int send_pct, int stall_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        @(negedge clk);
    endtask

    task automatic probe_config(logic [CFG_DATA_BITS-1:0] area, logic [CFG_DATA_BITS-1:0] inv);
        particle_t p;
        configure(area, inv);
        for (int i = 0; i < 3; i++)
        begin
            p = random_particle();
            p.last = (i == 2);
            send_particle(p);
        end
    endtask

    // Field extremes at reset register values
    task automatic test_directed_particles();
        logic [VALUE_BITS-1:0] vmax;
        logic [VALUE_BITS-1:0] vmin;
        logic [VALUE_BITS-1:0] vpos;
        logic [VALUE_BITS-1:0] one;
        vmax = '1;
        vmin = {1'b1, {(VALUE_BITS-1){1'b0}}};
        vpos = {1'b0, {(VALUE_BITS-1){1'b1}}};
        one = VALUE_BITS'(1 << 16);
        send_particle(make_particle('0, '0, '0, '0, '0, 1'b1));
        // at rest: energy is exactly zero
        send_particle(make_particle(vmax, vmax, '0, '0, '0, 1'b1));
        send_particle(make_particle('0, vmax, vmin, vmin, vmin, 1'b1));
        send_particle(make_particle('0, VALUE_BITS'(1), vpos, vmin, '0, 1'b0));
        send_particle(make_particle(one, one, one, '0, '0, 1'b0));
        send_particle(make_particle(vmax, vmax, vpos, vpos, vpos, 1'b1));
        send_particle(make_particle(VALUE_BITS'(1), '0, vmax, vmax, vmax, 1'b1));
        send_particle(make_particle(one, one, '0, VALUE_BITS'(3 << 16), vmax, 1'b1));
        wait_results_drained();
    endtask

    task automatic test_register_extremes();
        probe_config('0, '1);
        probe_config('1, '0);
        probe_config('1, '1);
        probe_config(CFG_DATA_BITS'(1), CFG_DATA_BITS'(1));
        probe_config(CELL_AREA_RESET, INV_COUNT_RESET);
    endtask

    // Push the sum past 2^64-1 with maximum-energy particles, then check the clear
    task automatic test_sum_saturation();
        logic [VALUE_BITS-1:0] vmin;
        vmin = {1'b1, {(VALUE_BITS-1){1'b0}}};
        configure('1, '1);
        set_idling(0, 0);
        for (int i = 1; i <= SATURATION_SET; i++)
            send_particle(make_particle('0, '1, vmin, vmin, vmin, i == SATURATION_SET));
        send_particle(random_particle());
        send_particle(make_particle('0, '1, vmin, vmin, vmin, 1'b1));
        wait_results_drained();
    endtask

    // Hold off the result side so the block backs up into its input
    task automatic test_output_holdoff();
        particle_t p;
        configure(pick_register(), pick_register());
        set_idling(0, 0);
        @(posedge clk);
        out_hold_left = 1500;
        @(negedge clk);
        for (int i = 0; i < 10; i++)
        begin
            p = random_particle();
            p.last = 1'b1;
            send_particle(p);
        end
        // pause the sender until all totals are back, then resume
        wait_results_drained();
        for (int i = 0; i < 4; i++)
            send_particle(random_particle());
        wait_results_drained();
    endtask

    task automatic run_random_phase(int send_pct, int stall_pct, int count);
        configure(pick_register(), pick_register());
        set_idling(send_pct, stall_pct);
        for (int i = 0; i < count; i++)
        begin
            send_particle(random_particle());
            if ($urandom_range(0, 59) == 0)
                wait_results_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_particles();
        test_register_extremes();
        test_sum_saturation();
        test_output_holdoff();
        run_random_phase(0, 0, 90);
        run_random_phase(52, 0, 90);
        run_random_phase(0, 52, 90);
        run_random_phase(17, 17, 90);
        settle_block();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
